// File: rtl/core/ascii_hex_frame_check_top_macros.svh
// Assertion macros shared by the frame check checker.
// Needs only a clock and an active-low reset at the point of use.
`ifndef ASCII_HEX_FRAME_CHECK_TOP_MACROS_SVH
`define ASCII_HEX_FRAME_CHECK_TOP_MACROS_SVH

// Same-cycle implication.
`define AHFC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("frame check assertion failed");

// Next-cycle implication.
`define AHFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("frame check assertion failed");

`endif

// File: rtl/core/ahfc_pkg.sv
// Shared types, codes and check functions of the ASCII hex frame check.
// No dependencies.
`default_nettype none

package ahfc_pkg;

	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_CHECK   = 2'd1;
	localparam logic [1:0] KIND_VERDICT = 2'd2;

	localparam logic [1:0] VERDICT_MATCH    = 2'd0;
	localparam logic [1:0] VERDICT_MISMATCH = 2'd1;
	localparam logic [1:0] VERDICT_SHORT    = 2'd2;

	localparam logic CFG_ALGORITHM = 1'b0;
	localparam logic CFG_MODE      = 1'b1;

	localparam logic [7:0] CRC_POLY     = 8'h8C;
	localparam logic [7:0] CHAR_ZERO    = 8'h30;
	localparam logic [7:0] CHAR_NINE    = 8'h39;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_F = 8'h46;
	localparam logic [7:0] ALPHA_BIAS   = CHAR_UPPER_A - 8'd10;
	localparam logic [3:0] NIBBLE_ALPHA = 4'hA;
	localparam logic [4:0] NIBBLE_BAD   = 5'h10;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] item_kind;
		logic [1:0] verdict;
		logic       last;
	} result_t;

	function automatic logic [7:0] fold(input logic alg, input logic [7:0] acc,
			input logic [7:0] b);
		logic [7:0] c;
		c = acc ^ b;
		if (!alg)
			return acc + b;
		for (int i = 0; i < 8; i++)
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		return c;
	endfunction

	function automatic logic [7:0] nibble_char(input logic [3:0] n);
		return (n >= NIBBLE_ALPHA) ? ({4'h0, n} + ALPHA_BIAS) : ({4'h0, n} + CHAR_ZERO);
	endfunction

	function automatic logic [4:0] char_nibble(input logic [7:0] c);
		logic [7:0] d;
		d = 8'h00;
		if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
			d = c - ALPHA_BIAS;
			return {1'b0, d[3:0]};
		end
		if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
			d = c - CHAR_ZERO;
			return {1'b0, d[3:0]};
		end
		return NIBBLE_BAD;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/ascii_hex_frame_check_top.sv
// ASCII hex frame check: sum or CRC-8 check, generate or verify, on a byte stream.
// Depends on ahfc_pkg.
// Path: input register, then result register; in_stall holds an item in the first.
// Throughput: one item per cycle unless stalled; its results leave one by one.
// Reset: asynchronous, clears config, message state and both stages' valid flags.
`default_nettype none

module ascii_hex_frame_check_top import ahfc_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic       cfg_index,
	input  wire logic       cfg_data,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] data_byte,
	input  wire logic       end_of_message,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      out_byte,
	output logic [1:0]      item_kind,
	output logic [1:0]      verdict,
	output logic            last_of_run
);

	localparam logic [1:0] HELD_FULL = 2'd2;

	logic       alg_q;
	logic       mode_q;
	logic [7:0] acc_q;
	logic [7:0] h0_q;
	logic [7:0] h1_q;
	logic [1:0] hc_q;

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       end_s1;

	result_t    res_q [3];
	logic [1:0] rem_q;

	logic       out_take;
	logic       buf_free;
	logic       s1_move;

	result_t    new_res [3];
	logic [1:0] new_cnt;
	logic [7:0] acc_d;
	logic [7:0] h0_d;
	logic [7:0] h1_d;
	logic [1:0] hc_d;
	logic [7:0] folded_b;
	logic [7:0] folded_h;
	logic [7:0] inv_b;
	logic [4:0] lo_n;
	logic [4:0] hi_n;
	logic       match;

	assign out_valid = (rem_q != 2'd0);
	assign out_take  = out_valid && !out_stall;
	assign buf_free  = (rem_q == 2'd0) || (out_take && rem_q == 2'd1);
	assign s1_move   = valid_s1 && buf_free;
	assign in_stall  = valid_s1 && !buf_free;

	assign out_byte    = res_q[0].out_byte;
	assign item_kind   = res_q[0].item_kind;
	assign verdict     = res_q[0].verdict;
	assign last_of_run = res_q[0].last;

	always_comb begin
		folded_b = fold(alg_q, acc_q, data_s1);
		folded_h = fold(alg_q, acc_q, h0_q);
		inv_b    = ~folded_b;
		lo_n     = char_nibble(h1_q);
		hi_n     = char_nibble(data_s1);
		match    = !lo_n[4] && !hi_n[4] && ({hi_n[3:0], lo_n[3:0]} == ~folded_h);
		acc_d    = acc_q;
		h0_d     = h0_q;
		h1_d     = h1_q;
		hc_d     = hc_q;
		new_cnt  = 2'd0;
		for (int k = 0; k < 3; k++)
			new_res[k] = '0;
		if (!mode_q) begin
			acc_d      = folded_b;
			new_res[0] = '{data_s1, KIND_PAYLOAD, VERDICT_MATCH, 1'b0};
			new_cnt    = 2'd1;
			if (end_s1) begin
				new_res[1] = '{nibble_char(inv_b[3:0]), KIND_CHECK, VERDICT_MATCH, 1'b0};
				new_res[2] = '{nibble_char(inv_b[7:4]), KIND_CHECK, VERDICT_MATCH, 1'b1};
				new_cnt    = 2'd3;
				acc_d      = '0;
				h0_d       = '0;
				h1_d       = '0;
				hc_d       = '0;
			end
		end else if (!end_s1) begin
			if (hc_q < HELD_FULL) begin
				if (hc_q[0])
					h1_d = data_s1;
				else
					h0_d = data_s1;
				hc_d = hc_q + 2'd1;
			end else begin
				acc_d      = folded_h;
				new_res[0] = '{h0_q, KIND_PAYLOAD, VERDICT_MATCH, 1'b0};
				new_cnt    = 2'd1;
				h0_d       = h1_q;
				h1_d       = data_s1;
			end
		end else begin
			if (hc_q < HELD_FULL) begin
				new_res[0] = '{8'h00, KIND_VERDICT, VERDICT_SHORT, 1'b1};
				new_cnt    = 2'd1;
			end else begin
				new_res[0] = '{h0_q, KIND_PAYLOAD, VERDICT_MATCH, 1'b0};
				new_res[1] = '{8'h00, KIND_VERDICT,
					match ? VERDICT_MATCH : VERDICT_MISMATCH, 1'b1};
				new_cnt    = 2'd2;
			end
			acc_d = '0;
			h0_d  = '0;
			h1_d  = '0;
			hc_d  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alg_q  <= 1'b0;
			mode_q <= 1'b0;
			acc_q  <= '0;
			h0_q   <= '0;
			h1_q   <= '0;
			hc_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ALGORITHM: alg_q  <= cfg_data;
				CFG_MODE:      mode_q <= cfg_data;
				default:       mode_q <= mode_q;
			endcase
			acc_q <= '0;
			h0_q  <= '0;
			h1_q  <= '0;
			hc_q  <= '0;
		end else if (s1_move) begin
			acc_q <= acc_d;
			h0_q  <= h0_d;
			h1_q  <= h1_d;
			hc_q  <= hc_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			rem_q    <= '0;
		end else begin
			if (in_valid && !in_stall)
				valid_s1 <= 1'b1;
			else if (s1_move)
				valid_s1 <= 1'b0;
			if (s1_move)
				rem_q <= new_cnt;
			else if (out_take)
				rem_q <= rem_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= data_byte;
			end_s1  <= end_of_message;
		end
		if (s1_move) begin
			res_q[0] <= new_res[0];
			res_q[1] <= new_res[1];
			res_q[2] <= new_res[2];
		end else if (out_take) begin
			res_q[0] <= res_q[1];
			res_q[1] <= res_q[2];
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/ahfc_checker.sv
// Port-level checker for the ASCII hex frame check, bound to the top level.
// Depends on ahfc_pkg and ascii_hex_frame_check_top_macros.svh.
`default_nettype none

`include "ascii_hex_frame_check_top_macros.svh"

module ahfc_checker import ahfc_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       cfg_we,
	input wire logic       cfg_index,
	input wire logic       cfg_data,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic [7:0] data_byte,
	input wire logic       end_of_message,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] out_byte,
	input wire logic [1:0] item_kind,
	input wire logic [1:0] verdict,
	input wire logic       last_of_run
);

	logic check_is_hex;
	logic cfg_seen;
	logic in_seen;

	assign check_is_hex = (out_byte >= CHAR_ZERO && out_byte <= CHAR_NINE) ||
		(out_byte >= CHAR_UPPER_A && out_byte <= CHAR_UPPER_F);
	assign cfg_seen = cfg_we && (cfg_index == CFG_MODE || cfg_data == 1'b1);
	assign in_seen  = in_valid && (data_byte != 8'h00 || end_of_message);

	`AHFC_ASSERT_NOW(a_verdict_form, clk, arst_n, out_valid && item_kind == KIND_VERDICT, out_byte == 8'h00 && last_of_run)
	`AHFC_ASSERT_NOW(a_check_hex, clk, arst_n, out_valid && item_kind == KIND_CHECK, check_is_hex)
	`AHFC_ASSERT_NOW(a_verdict_zero, clk, arst_n, out_valid && item_kind != KIND_VERDICT, verdict == VERDICT_MATCH)
	`AHFC_ASSERT_NEXT(a_check_pair, clk, arst_n, out_valid && !out_stall && item_kind == KIND_CHECK && !last_of_run, out_valid && item_kind == KIND_CHECK && last_of_run)
	`AHFC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall && (cfg_seen || !cfg_seen) && (in_seen || !in_seen), out_valid && $stable(out_byte) && $stable(item_kind) && $stable(last_of_run))

endmodule

bind ascii_hex_frame_check_top ahfc_checker u_ahfc_checker (.*);

`default_nettype wire
